// File: rtl/core/lcdfs_pkg.sv
// ----------------------------------------------------------------------------
// lcdfs_pkg
// Shared types and constants for the folded frame store with dirty flush.
// ----------------------------------------------------------------------------
package lcdfs_pkg;
   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;
   localparam int ROWS      = SCREEN_HEIGHT_DEF / 2;
   localparam int ROW_BYTES = SCREEN_WIDTH_DEF / 4;
   localparam int WORDS     = SCREEN_WIDTH_DEF / 8;
   localparam int ADDR_W    = $clog2(ROWS * ROW_BYTES);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int COL_W     = $clog2(ROW_BYTES);
   localparam int WORD_W    = $clog2(WORDS);
   localparam int CMD_QDEPTH = 4;

   localparam logic [7:0] ROW_CMD_RESET = 8'b10000000;
   localparam logic [7:0] COL_CMD_RESET = 8'b10000000;

   localparam logic [2:0] K_CLEAR = 3'd0;
   localparam logic [2:0] K_PUT   = 3'd1;
   localparam logic [2:0] K_GET   = 3'd2;
   localparam logic [2:0] K_PAIR  = 3'd3;
   localparam logic [2:0] K_FULL  = 3'd4;
   localparam logic [2:0] K_FAST  = 3'd5;

   localparam logic [1:0] O_PIXEL = 2'd0;
   localparam logic [1:0] O_CMD   = 2'd1;
   localparam logic [1:0] O_DATA  = 2'd2;

   localparam logic [0:0] CSR_ROW_BASE = 1'd0;
   localparam logic [0:0] CSR_COL_BASE = 1'd1;

   // classified command handed from front to back
   typedef struct packed {
      logic [2:0]       kind;
      logic [ROW_W-1:0] row;
      logic [7:0]       bitpos;   // pixel position within folded row, 0..255
      logic             pixel_on;
      logic [5:0]       col;      // byte column of a byte pair, up to 47; 63 when x is past 31
      logic [7:0]       first_byte;
      logic [7:0]       second_byte;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } rsp_type;
endpackage

// File: rtl/core/lcd_frame_store_dirty_flush.sv
// ----------------------------------------------------------------------------
// lcd_frame_store_dirty_flush
// 128x64 folded frame store with dirty-word tracking and row flush.
// ----------------------------------------------------------------------------
// A pixel read word passes the command queue, the memory read register and the
//   two-word result queue. Throughput: get one per cycle while the queue has
//   room; a put reads then rewrites its byte, a byte pair writes both bytes in
//   turn, a full flush emits two command words and 32 data bytes, a fast flush
//   two of each per dirty word; single memory port. Reads and flush words wait
//   while the result queue is full. Reset: synchronous; a clearing pass of the
//   frame memory follows, queueing at most four words; Clear runs the same pass.
module lcd_frame_store_dirty_flush
   import lcdfs_pkg::*;
#(
   parameter int QDEPTH = CMD_QDEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       full,
   input  logic [2:0] req_kind,
   input  logic [6:0] req_x,
   input  logic [5:0] req_y,
   input  logic       req_pixel_on,
   input  logic [7:0] req_first_byte,
   input  logic [7:0] req_second_byte,
   input  logic [4:0] req_flush_row,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   logic [7:0] row_base_ff, col_base_ff;
   logic       cmd_valid, cmd_take;
   cmd_type    cmd;
   rsp_type    rsp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff <= ROW_CMD_RESET;
         col_base_ff <= COL_CMD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ROW_BASE: row_base_ff <= csr_data;
            CSR_COL_BASE: col_base_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lcdfs_front #(.QDEPTH(QDEPTH)) u_front (
      .clock, .reset, .req_push, .full, .req_kind, .req_x, .req_y,
      .req_pixel_on, .req_first_byte, .req_second_byte, .req_flush_row,
      .cmd_valid, .cmd, .cmd_take
   );

   lcdfs_back u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take,
      .row_base(row_base_ff), .col_base(col_base_ff),
      .empty, .pop, .rsp
   );

   assign rsp_out_kind = rsp.kind;
   assign rsp_out_byte = rsp.data;
   assign rsp_last     = rsp.last;

   a_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_out_kind != 2'd3) else $error("bad result kind");
   a_pix: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_kind == O_PIXEL) |-> (rsp_out_byte[7:1] == 7'd0 && rsp_last))
      else $error("pixel word malformed");
endmodule

// File: rtl/core/lcdfs_front.sv
// ----------------------------------------------------------------------------
// lcdfs_front
// Accepts request words, folds coordinates, queues commands for the back end.
// ----------------------------------------------------------------------------
module lcdfs_front
   import lcdfs_pkg::*;
#(
   parameter int QDEPTH = CMD_QDEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       full,
   input  logic [2:0] req_kind,
   input  logic [6:0] req_x,
   input  logic [5:0] req_y,
   input  logic       req_pixel_on,
   input  logic [7:0] req_first_byte,
   input  logic [7:0] req_second_byte,
   input  logic [4:0] req_flush_row,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_take
);
   localparam int QA = $clog2(QDEPTH);
   cmd_type          q_ff [QDEPTH];
   logic [QA-1:0]    wp_ff, rp_ff;
   logic [QA:0]      cnt_ff;
   cmd_type          c_in;
   logic             push;

   always_comb begin
      c_in = '0;
      c_in.kind        = req_kind;
      c_in.pixel_on    = req_pixel_on;
      c_in.first_byte  = req_first_byte;
      c_in.second_byte = req_second_byte;
      c_in.row         = (req_kind == K_FULL || req_kind == K_FAST) ?
                         req_flush_row : req_y[ROW_W-1:0];
      // lower screen half sits 128 pixels further along the folded row
      c_in.bitpos      = {req_y[5], req_x};
      c_in.col         = {1'b0, req_x[4:0]} + {1'b0, req_y[5], 4'd0};
      if (req_x[6:5] != 2'd0) c_in.col = 6'd63;
   end

   assign full      = (cnt_ff == (QA+1)'(QDEPTH));
   assign push      = req_push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c_in;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (cmd_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QA+1)'(push) - (QA+1)'(cmd_take);
      end
   end
endmodule

// File: rtl/core/lcdfs_back.sv
// ----------------------------------------------------------------------------
// lcdfs_back
// Runs commands against the frame memory and dirty bits, emits result words.
// ----------------------------------------------------------------------------
module lcdfs_back
   import lcdfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_take,
   input  logic [7:0] row_base,
   input  logic [7:0] col_base,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_PAIR2, S_FULL, S_FAST, S_WAIT
   } state_type;

   logic [7:0]           mem [ROWS*ROW_BYTES];
   logic [WORDS-1:0]     dirty_ff [ROWS];
   state_type            st_ff;
   logic [ADDR_W-1:0]    clr_ff;
   cmd_type              c_ff;
   logic [COL_W:0]       idx_ff;   // full: column+2, fast: sub-step
   logic [WORD_W:0]      w_ff;
   logic [WORDS-1:0]     dmask_ff;
   logic [7:0]           rd_ff;
   logic                 rd_pend_ff;
   logic [1:0]           rd_kind_ff;
   logic                 rd_last_ff, rd_pix_ff;
   logic [2:0]           rd_bit_ff;
   // output queue of two words
   rsp_type              oq_ff [2];
   logic                 ow_ff, orp_ff;
   logic [1:0]           ocnt_ff;

   logic                 we, oen, rd_en, opush;
   logic [ADDR_W-1:0]    waddr, raddr;
   logic [7:0]           wdata, rbyte;
   rsp_type              onew;
   logic                 room;
   logic [ADDR_W-1:0]    pix_addr;
   logic [WORD_W-1:0]    cur_w;
   logic [WORDS-1:0]     rest;
   logic                 dirty_cur, fast_go;

   function automatic logic [7:0] pmask_c(input logic [2:0] b);
      pmask_c = 8'h80 >> b;
   endfunction

   assign pix_addr = {cmd.row, cmd.bitpos[7:3]} ;
   assign empty    = (ocnt_ff == 2'd0);
   assign rsp      = oq_ff[orp_ff];
   // room: reserve a slot for an in-flight read
   assign room     = (ocnt_ff + 2'(rd_pend_ff)) < 2'd2 || (pop && !empty
                     && ocnt_ff + 2'(rd_pend_ff) == 2'd2);
   assign cur_w    = w_ff[WORD_W-1:0];
   assign dirty_cur = dmask_ff[WORDS-1-cur_w];
   // a command word must not meet the data word of the previous dirty word
   assign fast_go  = room && rest != '0 && dirty_cur &&
                     !(idx_ff[1:0] < 2'd2 && rd_pend_ff);

   always_comb begin
      rest = '0;
      for (int i = 0; i < WORDS; i++)
         if (i >= int'(w_ff)) rest[WORDS-1-i] = dmask_ff[WORDS-1-i];
   end

   always_comb begin
      we = 1'b0; waddr = '0; wdata = '0;
      rd_en = 1'b0; raddr = '0;
      oen = 1'b0; onew = '0;
      cmd_take = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  K_PUT: begin
                     cmd_take = 1'b1;
                  end
                  K_GET: begin
                     cmd_take = room;
                  end
                  K_PAIR: begin
                     cmd_take = 1'b1;
                     we = !cmd.col[5];
                     waddr = {cmd.row, cmd.col[COL_W-1:0]};
                     wdata = cmd.first_byte;
                  end
                  K_FULL, K_FAST: cmd_take = 1'b1;
                  default: cmd_take = 1'b1;
               endcase
            end
         end
         S_WAIT: begin
            // put pixel read-modify-write
            we = 1'b1; waddr = {c_ff.row, c_ff.bitpos[7:3]};
            wdata = c_ff.pixel_on ? (rbyte | pmask_c(c_ff.bitpos[2:0]))
                                  : (rbyte & ~pmask_c(c_ff.bitpos[2:0]));
         end
         S_PAIR2: begin
            we = (c_ff.col < 6'd31);
            waddr = {c_ff.row, COL_W'(c_ff.col + 6'd1)};
            wdata = c_ff.second_byte;
         end
         S_FULL: begin
            if (room) begin
               if (idx_ff < (COL_W+1)'(2)) begin
                  oen = 1'b1;
                  onew.kind = O_CMD;
                  onew.data = (idx_ff == '0) ? row_base + 8'(c_ff.row) : col_base;
               end else begin
                  rd_en = 1'b1;
                  raddr = {c_ff.row, COL_W'(idx_ff - (COL_W+1)'(2))};
               end
            end
         end
         S_FAST: begin
            if (fast_go) begin
               if (idx_ff[1:0] < 2'd2) begin
                  oen = 1'b1;
                  onew.kind = O_CMD;
                  onew.data = (idx_ff[1:0] == 2'd0) ? row_base + 8'(c_ff.row)
                                                    : col_base + 8'(cur_w);
               end else begin
                  rd_en = 1'b1;
                  raddr = {c_ff.row, cur_w, idx_ff[0]};
               end
            end
         end
         default: ;
      endcase
   end

   assign rbyte = rd_ff;
   logic rd_out;
   assign rd_out = rd_pend_ff;
   always_comb begin
      opush = oen || rd_out;
   end

   // memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   logic [ADDR_W-1:0] ra;
   logic              rdo;
   always_comb begin
      ra = raddr; rdo = rd_en;
      if (st_ff == S_IDLE && cmd_valid &&
          (cmd.kind == K_PUT || (cmd.kind == K_GET && room))) begin
         ra = pix_addr; rdo = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (rdo) rd_ff <= mem[ra];
   end

   rsp_type rdw;
   always_comb begin
      rdw.kind = rd_kind_ff;
      rdw.last = rd_last_ff;
      rdw.data = rd_pix_ff ? {7'd0, rd_ff[3'd7 - rd_bit_ff]} : rd_ff;
   end

   logic last_full, last_fast;
   assign last_full = (idx_ff == (COL_W+1)'(ROW_BYTES + 1));
   always_comb begin
      last_fast = idx_ff[1:0] == 2'd3;
      for (int i = 0; i < WORDS; i++)
         if (i > int'(w_ff) && dmask_ff[WORDS-1-i]) last_fast = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (opush) begin
         oq_ff[ow_ff] <= rd_out ? rdw : onew;
      end
      if (st_ff == S_IDLE && cmd_take) c_ff <= cmd;
      if (st_ff == S_IDLE && cmd_take && cmd.kind == K_FAST) dmask_ff <= dirty_ff[cmd.row];
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0;
         ow_ff <= 1'b0; orp_ff <= 1'b0; ocnt_ff <= '0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) dirty_ff[i] <= '0;
      end else begin
         if (opush) ow_ff <= ~ow_ff;
         if (pop && !empty) orp_ff <= ~orp_ff;
         ocnt_ff <= ocnt_ff + 2'(opush) - 2'(pop && !empty);
         rd_pend_ff <= 1'b0;
         case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) st_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_take) begin
                  idx_ff <= '0; w_ff <= '0;
                  case (cmd.kind)
                     K_CLEAR: begin
                        st_ff <= S_CLEAR; clr_ff <= '0;
                        for (int i = 0; i < ROWS; i++) dirty_ff[i] <= '0;
                     end
                     K_PUT: begin
                        st_ff <= S_WAIT;
                        dirty_ff[cmd.row][WORDS-1-cmd.bitpos[7:4]] <= 1'b1;
                     end
                     K_GET: begin
                        // taken only when the result queue has room
                        st_ff <= S_IDLE;
                     end
                     K_PAIR:  st_ff <= S_PAIR2;
                     K_FULL:  st_ff <= S_FULL;
                     K_FAST:  begin
                        st_ff <= S_FAST;
                        dirty_ff[cmd.row] <= '0;
                     end
                     default: st_ff <= S_IDLE;
                  endcase
               end
            end
            S_WAIT:  st_ff <= S_IDLE;
            S_PAIR2: st_ff <= S_IDLE;
            S_FULL: begin
               if (room) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (last_full) st_ff <= S_IDLE;
               end
            end
            S_FAST: begin
               if (rest == '0) st_ff <= S_IDLE;
               // skip clean words
               else if (!dirty_cur) w_ff <= w_ff + 1'b1;
               else if (fast_go) begin
                  if (idx_ff[1:0] == 2'd3) begin
                     idx_ff <= '0;
                     w_ff <= w_ff + 1'b1;
                  end else idx_ff <= idx_ff + 1'b1;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
         if (rdo && !(st_ff == S_IDLE && cmd_valid && cmd.kind == K_PUT))
            rd_pend_ff <= 1'b1;
      end
      if (st_ff == S_IDLE && cmd_valid && cmd.kind == K_GET) begin
         rd_kind_ff <= O_PIXEL; rd_last_ff <= 1'b1; rd_pix_ff <= 1'b1;
         rd_bit_ff <= cmd.bitpos[2:0];
      end else if (st_ff == S_FULL) begin
         rd_kind_ff <= O_DATA; rd_last_ff <= last_full; rd_pix_ff <= 1'b0;
      end else if (st_ff == S_FAST) begin
         rd_kind_ff <= O_DATA; rd_last_ff <= last_fast; rd_pix_ff <= 1'b0;
      end
   end
endmodule
